// ===== rtl/core/rsc_pkg.sv =====
// ============================================================================
// rsc_pkg: shared types and constants for the record stream checker
// Character codes, byte classes, error codes, phase encodings and the
// result record that goes from the checking core to the output register.
// ============================================================================
`default_nettype none

package rsc_pkg;

  // Characters recognised in the byte stream.
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_TAB         = 8'h09;
  localparam logic [7:0] CH_LF          = 8'h0A;
  localparam logic [7:0] CH_VT          = 8'h0B;
  localparam logic [7:0] CH_FF          = 8'h0C;
  localparam logic [7:0] CH_CR          = 8'h0D;
  localparam logic [7:0] CH_GT          = 8'h3E;
  localparam logic [7:0] CH_G           = 8'h47;
  localparam logic [7:0] CH_C           = 8'h43;
  localparam logic [7:0] CH_A           = 8'h41;
  localparam logic [7:0] CH_U           = 8'h55;
  localparam logic [7:0] CH_T           = 8'h54;
  localparam logic [7:0] CH_OPEN_ROUND  = 8'h28;
  localparam logic [7:0] CH_CLOSE_ROUND = 8'h29;
  localparam logic [7:0] CH_OPEN_SQ     = 8'h5B;
  localparam logic [7:0] CH_CLOSE_SQ    = 8'h5D;
  localparam logic [7:0] CH_DOT         = 8'h2E;

  // Widths fixed by the result fields.
  localparam int unsigned REC_LEN_W = 16;
  localparam int unsigned LINE_W    = 32;

  // Classification of one byte.
  typedef struct packed {
    logic is_space;
    logic is_newline;
    logic is_header_mark;
    logic is_base;
    logic is_dot;
    logic is_open_round;
    logic is_close_round;
    logic is_open_square;
    logic is_close_square;
  } byte_class_t;

  // Class of a plain space, used for whitespace held inside a line.
  localparam byte_class_t SPACE_CLASS = '{
    is_space: 1'b1, is_newline: 1'b0, is_header_mark: 1'b0, is_base: 1'b0,
    is_dot: 1'b0, is_open_round: 1'b0, is_close_round: 1'b0,
    is_open_square: 1'b0, is_close_square: 1'b0
  };

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_HEADER = 3'd1,
    ERR_EMPTY     = 3'd2,
    ERR_LENGTH    = 3'd3,
    ERR_SEQUENCE  = 3'd4,
    ERR_STRUCTURE = 3'd5,
    ERR_TOO_LONG  = 3'd6
  } err_code_t;

  // Record phase: which line of the record is expected next.
  typedef enum logic [3:0] {
    PH_UNINIT = 4'b0001,
    PH_SEQ    = 4'b0010,
    PH_STRUCT = 4'b0100,
    PH_NAME   = 4'b1000
  } rec_phase_t;

  // Line phase: position within the current line.
  typedef enum logic [2:0] {
    LN_START = 3'b001,
    LN_LEAD  = 3'b010,
    LN_BODY  = 3'b100
  } line_phase_t;

  // One result transaction.
  typedef struct packed {
    logic                   record_done;
    logic [REC_LEN_W-1:0]   record_length;
    logic                   error_flag;
    err_code_t              error_code;
    logic [LINE_W-1:0]      error_line;
    logic                   file_done;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/rsc_char_class.sv =====
// ============================================================================
// rsc_char_class: byte classifier
// Decodes one file byte into the character classes used by the checker.
// ============================================================================
`default_nettype none

module rsc_char_class (
  input  wire logic [7:0]          data_byte,
  output rsc_pkg::byte_class_t     byte_class
);

  // Decode the byte; every unlisted code is plain content with no class.
  always_comb begin
    byte_class = '0;
    unique case (data_byte) inside
      rsc_pkg::CH_LF: begin
        byte_class.is_space   = 1'b1;
        byte_class.is_newline = 1'b1;
      end
      rsc_pkg::CH_SPACE, rsc_pkg::CH_TAB, rsc_pkg::CH_CR,
      rsc_pkg::CH_FF, rsc_pkg::CH_VT: begin
        byte_class.is_space = 1'b1;
      end
      rsc_pkg::CH_GT: begin
        byte_class.is_header_mark = 1'b1;
      end
      rsc_pkg::CH_G, rsc_pkg::CH_C, rsc_pkg::CH_A,
      rsc_pkg::CH_U, rsc_pkg::CH_T: begin
        byte_class.is_base = 1'b1;
      end
      rsc_pkg::CH_DOT: begin
        byte_class.is_dot = 1'b1;
      end
      rsc_pkg::CH_OPEN_ROUND: begin
        byte_class.is_open_round = 1'b1;
      end
      rsc_pkg::CH_CLOSE_ROUND: begin
        byte_class.is_close_round = 1'b1;
      end
      rsc_pkg::CH_OPEN_SQ: begin
        byte_class.is_open_square = 1'b1;
      end
      rsc_pkg::CH_CLOSE_SQ: begin
        byte_class.is_close_square = 1'b1;
      end
      default: begin
        byte_class = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rsc_check_core.sv =====
// ============================================================================
// rsc_check_core: record checking state and its combinational update
// Holds the line and record state, works out the next state and the result
// for one byte or end-of-file transaction, and commits it when stepped.
// ============================================================================
`default_nettype none

module rsc_check_core #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic                 end_of_file,
  input  rsc_pkg::byte_class_t      byte_class,
  output rsc_pkg::result_t          result
);

  localparam int unsigned DEPTH_W = LENGTH_BITS + 1;

  typedef struct packed {
    rsc_pkg::rec_phase_t            rec_phase;
    rsc_pkg::line_phase_t           line_phase;
    logic                           hdr;
    logic                           pending;
    logic                           bad;
    logic                           name;
    logic [LENGTH_BITS-1:0]         seq_len;
    logic [LENGTH_BITS-1:0]         str_len;
    logic [DEPTH_W-1:0]             round_d;
    logic [DEPTH_W-1:0]             square_d;
    logic [rsc_pkg::LINE_W-1:0]     line_count;
    rsc_pkg::err_code_t             err;
  } chk_state_t;

  localparam chk_state_t RESET_STATE = '{
    rec_phase: rsc_pkg::PH_UNINIT, line_phase: rsc_pkg::LN_START,
    hdr: 1'b0, pending: 1'b0, bad: 1'b0, name: 1'b0,
    seq_len: '0, str_len: '0, round_d: '0, square_d: '0,
    line_count: '0, err: rsc_pkg::ERR_NONE
  };

  // Keep only the first error.
  function automatic chk_state_t raise_err(chk_state_t s, rsc_pkg::err_code_t code);
    chk_state_t r;
    r = s;
    if (r.err == rsc_pkg::ERR_NONE) begin
      r.err = code;
    end
    return r;
  endfunction

  // Verdict on the record held so far: none when it is accepted.
  function automatic rsc_pkg::err_code_t close_code(chk_state_t s);
    rsc_pkg::err_code_t c;
    c = rsc_pkg::ERR_NONE;
    if (s.seq_len == '0 || s.str_len == '0) begin
      c = rsc_pkg::ERR_EMPTY;
    end else if (s.seq_len != s.str_len) begin
      c = rsc_pkg::ERR_LENGTH;
    end
    return c;
  endfunction

  // One content character of a header, sequence or structure line.
  function automatic chk_state_t content(chk_state_t s, rsc_pkg::byte_class_t c);
    chk_state_t r;
    logic       counted;
    r       = s;
    counted = 1'b1;
    if (r.hdr) begin
      if (!c.is_space) begin
        r.name = 1'b1;
      end
    end else if (!r.bad) begin
      if (r.rec_phase == rsc_pkg::PH_SEQ) begin
        if (!c.is_base) begin
          r.bad = 1'b1;
        end else if (r.seq_len == '1) begin
          r = raise_err(r, rsc_pkg::ERR_TOO_LONG);
        end else begin
          r.seq_len = r.seq_len + 1'b1;
        end
      end else begin
        if (c.is_open_round) begin
          r.round_d = r.round_d + 1'b1;
        end else if (c.is_close_round) begin
          if (r.round_d == '0) begin
            r.bad   = 1'b1;
            counted = 1'b0;
          end else begin
            r.round_d = r.round_d - 1'b1;
          end
        end else if (c.is_open_square) begin
          r.square_d = r.square_d + 1'b1;
        end else if (c.is_close_square) begin
          if (r.square_d == '0) begin
            r.bad   = 1'b1;
            counted = 1'b0;
          end else begin
            r.square_d = r.square_d - 1'b1;
          end
        end else if (!c.is_dot) begin
          r.bad   = 1'b1;
          counted = 1'b0;
        end
        if (counted) begin
          if (r.str_len == '1) begin
            r = raise_err(r, rsc_pkg::ERR_TOO_LONG);
          end else begin
            r.str_len = r.str_len + 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // Close the current line and judge a finished sequence or structure line.
  function automatic chk_state_t end_line(chk_state_t s);
    chk_state_t r;
    r = s;
    if (r.line_phase == rsc_pkg::LN_BODY && !r.hdr) begin
      if (r.rec_phase == rsc_pkg::PH_SEQ) begin
        if (r.bad) begin
          r = raise_err(r, rsc_pkg::ERR_SEQUENCE);
        end else begin
          r.rec_phase = rsc_pkg::PH_STRUCT;
        end
      end else if (r.rec_phase == rsc_pkg::PH_STRUCT) begin
        if (r.bad || r.round_d != '0 || r.square_d != '0) begin
          r = raise_err(r, rsc_pkg::ERR_STRUCTURE);
        end else begin
          r.rec_phase = rsc_pkg::PH_NAME;
        end
      end
    end
    r.line_phase = rsc_pkg::LN_START;
    r.hdr        = 1'b0;
    r.pending    = 1'b0;
    r.bad        = 1'b0;
    return r;
  endfunction

  chk_state_t            state;
  chk_state_t            state_next;
  chk_state_t            work;
  logic                  done;
  logic [LENGTH_BITS-1:0] done_len;
  rsc_pkg::err_code_t    verdict;
  rsc_pkg::byte_class_t  eff_class;

  // Next state and result for the transaction in the input register.
  always_comb begin
    work     = state;
    done     = 1'b0;
    done_len = '0;
    verdict  = rsc_pkg::ERR_NONE;
    // Whitespace held inside a sequence or structure line spoils the line.
    eff_class = (state.pending && !state.hdr) ? rsc_pkg::SPACE_CLASS : byte_class;

    if (end_of_file) begin
      if (state.err == rsc_pkg::ERR_NONE && state.line_phase != rsc_pkg::LN_START) begin
        work = end_line(work);
      end
      if (work.err == rsc_pkg::ERR_NONE && work.name) begin
        verdict = close_code(work);
        if (verdict == rsc_pkg::ERR_NONE) begin
          done     = 1'b1;
          done_len = work.seq_len;
        end else begin
          work = raise_err(work, verdict);
        end
      end
    end else if (state.err == rsc_pkg::ERR_NONE) begin
      if (work.line_phase == rsc_pkg::LN_START) begin
        if (work.line_count != '1) begin
          work.line_count = work.line_count + 1'b1;
        end
        work.line_phase = rsc_pkg::LN_LEAD;
      end
      if (byte_class.is_newline) begin
        work = end_line(work);
      end else if (byte_class.is_space) begin
        if (work.line_phase == rsc_pkg::LN_BODY) begin
          work.pending = 1'b1;
        end
      end else if (work.line_phase == rsc_pkg::LN_LEAD) begin
        // First visible character of a line.
        work.line_phase = rsc_pkg::LN_BODY;
        if (byte_class.is_header_mark) begin
          work.hdr = 1'b1;
          if (work.rec_phase != rsc_pkg::PH_UNINIT) begin
            verdict = close_code(work);
            if (verdict == rsc_pkg::ERR_NONE) begin
              done     = 1'b1;
              done_len = work.seq_len;
            end else begin
              work = raise_err(work, verdict);
            end
          end
          if (work.err == rsc_pkg::ERR_NONE) begin
            work.seq_len   = '0;
            work.str_len   = '0;
            work.round_d   = '0;
            work.square_d  = '0;
            work.name      = 1'b0;
            work.rec_phase = rsc_pkg::PH_SEQ;
          end
        end else if (work.rec_phase == rsc_pkg::PH_UNINIT ||
                     work.rec_phase == rsc_pkg::PH_NAME) begin
          work = raise_err(work, rsc_pkg::ERR_NO_HEADER);
        end else begin
          work = content(work, byte_class);
        end
      end else begin
        work         = content(work, eff_class);
        work.pending = 1'b0;
      end
    end

    state_next = end_of_file ? RESET_STATE : work;

    result.record_done   = done;
    result.record_length = done ? rsc_pkg::REC_LEN_W'(done_len) : '0;
    result.error_flag    = (work.err != rsc_pkg::ERR_NONE);
    result.error_code    = work.err;
    result.error_line    = (work.err != rsc_pkg::ERR_NONE) ? work.line_count : '0;
    result.file_done     = end_of_file;
  end

  // State register, committed once per processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RESET_STATE;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rna_record_stream_checker_unit.sv =====
// An accepted transaction is held in the input register and its result in the output register.
// Throughput: one byte or end-of-file transaction per cycle while out_ready holds;
//   the limit is the update loop of the checking state register.
// Reset (synchronous): clears the checking state and empties both registers.
// An end-of-file transaction also returns the checking state to its reset value.
// ============================================================================
// rna_record_stream_checker_unit: three-line record stream checker
// Input register, checking core and output register with valid/ready on
// both sides; validates header, sequence and dot-bracket structure lines.
// ============================================================================
`default_nettype none

module rna_record_stream_checker_unit #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            end_of_file,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 record_done,
  output logic [rsc_pkg::REC_LEN_W-1:0]        record_length,
  output logic                                 error_flag,
  output logic [2:0]                           error_code,
  output logic [rsc_pkg::LINE_W-1:0]           error_line,
  output logic                                 file_done
);

  logic                  s0_valid;
  logic [7:0]            s0_byte;
  logic                  s0_eof;
  logic                  advance;
  rsc_pkg::byte_class_t  s0_class;
  rsc_pkg::result_t      core_result;
  rsc_pkg::result_t      out_q;

  // Handshake: the input register moves on when the output register can take.
  assign advance  = s0_valid && (!out_valid || out_ready);
  assign in_ready = !s0_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= (in_valid && in_ready) || (s0_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_byte <= data_byte;
      s0_eof  <= end_of_file;
    end
  end

  rsc_char_class u_char_class (
    .data_byte  (s0_byte),
    .byte_class (s0_class)
  );

  rsc_check_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_check_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .end_of_file (s0_eof),
    .byte_class  (s0_class),
    .result      (core_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= core_result;
    end
  end

  assign record_done   = out_q.record_done;
  assign record_length = out_q.record_length;
  assign error_flag    = out_q.error_flag;
  assign error_code    = out_q.error_code;
  assign error_line    = out_q.error_line;
  assign file_done     = out_q.file_done;

  // An accepted record never coincides with a held error.
  a_done_no_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_done) |-> !error_flag)
    else $error("record reported while an error is held");

  // The error flag and the error code agree.
  a_flag_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_flag == (error_code != rsc_pkg::ERR_NONE)))
    else $error("error flag and error code disagree");

  // A held error always points at a line that has been started.
  a_error_line: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_flag) |-> (error_line != '0))
    else $error("error reported without a line number");

  // A stalled transaction stays in the input register.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s0_valid && !advance) |=> (s0_valid && $stable(s0_byte) && $stable(s0_eof)))
    else $error("stalled input transaction lost");

endmodule

`default_nettype wire
